FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The given condition never holds.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: design/mpct_pkg.sv
`default_nettype none

package mpct_pkg;

  localparam int FIELD_BITS       = 12;
  localparam int BYTE_BITS        = 8;
  localparam int DEF_COORD_BITS   = 12;
  localparam int SIGN_X_POS       = 4;
  localparam int SIGN_Y_POS       = 5;

  localparam logic [FIELD_BITS-1:0] MAX_X_RESET = 12'd639;
  localparam logic [FIELD_BITS-1:0] MAX_Y_RESET = 12'd479;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = 1'd1;

  typedef logic [1:0] byte_pos_t;
  localparam byte_pos_t POS_STATUS = 2'd0;
  localparam byte_pos_t POS_X      = 2'd1;
  localparam byte_pos_t POS_Y      = 2'd2;

endpackage

`default_nettype wire

FILE: design/mouse_packet_cursor_tracker.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_packet_byte[7:0]
// out     | output    | out_valid / out_stall| out_old_x, out_old_y, out_new_x, out_new_y [11:0]
// cfg     | input     | cfg_valid / cfg_ready| cfg_index[0], cfg_data[11:0]
//
// One byte per cycle while in_stall is low; the Y byte is folded into the cursor in the
// same cycle and the result sits in the output register in the cycle after its transfer.
// Status and X bytes are taken even while a result waits; a Y byte waits only while
// the output register is full and stalled.
// Synchronous active-low reset clears byte position, cursor and out_valid, and sets the limits to 639 and 479.
// cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = mpct_pkg::DEF_COORD_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mpct_pkg::BYTE_BITS-1:0]  in_packet_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mpct_pkg::FIELD_BITS-1:0]      out_old_x,
  output logic [mpct_pkg::FIELD_BITS-1:0]      out_old_y,
  output logic [mpct_pkg::FIELD_BITS-1:0]      out_new_x,
  output logic [mpct_pkg::FIELD_BITS-1:0]      out_new_y,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mpct_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [mpct_pkg::FIELD_BITS-1:0] cfg_data
);

  localparam int FB = mpct_pkg::FIELD_BITS;
  localparam int BB = mpct_pkg::BYTE_BITS;
  localparam int CB = (FB > COORD_BITS) ? FB : COORD_BITS;
  localparam int AW = CB + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CB-1:0]         lim_t;

  mpct_pkg::byte_pos_t pos_r, pos_nxt;
  logic [BB-1:0] status_r, xmove_r;
  coord_t        cursor_x_r, cursor_y_r, cursor_x_nxt, cursor_y_nxt;
  logic [FB-1:0] max_x_r, max_y_r;
  logic          out_valid_r;
  logic [FB-1:0] out_old_x_r, out_old_y_r, out_new_x_r, out_new_y_r;

  logic          in_xfer, out_xfer, pkt_done;
  logic signed [AW-1:0] dx, dy, nx, ny;
  lim_t          top_x, top_y, coord_mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = (pos_r == mpct_pkg::POS_Y) && out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign pkt_done  = in_xfer && (pos_r == mpct_pkg::POS_Y);

  always_comb begin
    case (pos_r)
      mpct_pkg::POS_STATUS: pos_nxt = mpct_pkg::POS_X;
      mpct_pkg::POS_X:      pos_nxt = mpct_pkg::POS_Y;
      mpct_pkg::POS_Y:      pos_nxt = mpct_pkg::POS_STATUS;
      default:              pos_nxt = mpct_pkg::POS_X;
    endcase
  end

  // 9-bit movements, sign from the held status byte
  assign dx = AW'(signed'({status_r[mpct_pkg::SIGN_X_POS], xmove_r}));
  assign dy = AW'(signed'({status_r[mpct_pkg::SIGN_Y_POS], in_packet_byte}));
  assign nx = signed'(AW'(cursor_x_r)) + dx;
  assign ny = signed'(AW'(cursor_y_r)) - dy;

  assign coord_mask = CB'({COORD_BITS{1'b1}});
  assign top_x = (CB'(max_x_r) < coord_mask) ? CB'(max_x_r) : coord_mask;
  assign top_y = (CB'(max_y_r) < coord_mask) ? CB'(max_y_r) : coord_mask;

  always_comb begin
    if (nx < 0) begin
      cursor_x_nxt = '0;
    end else if (nx > signed'(AW'(top_x))) begin
      cursor_x_nxt = COORD_BITS'(top_x);
    end else begin
      cursor_x_nxt = COORD_BITS'(nx);
    end
    if (ny < 0) begin
      cursor_y_nxt = '0;
    end else if (ny > signed'(AW'(top_y))) begin
      cursor_y_nxt = COORD_BITS'(top_y);
    end else begin
      cursor_y_nxt = COORD_BITS'(ny);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= mpct_pkg::POS_STATUS;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      max_x_r     <= mpct_pkg::MAX_X_RESET;
      max_y_r     <= mpct_pkg::MAX_Y_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mpct_pkg::REG_MAX_X: max_x_r <= cfg_data;
          mpct_pkg::REG_MAX_Y: max_y_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        pos_r <= pos_nxt;
      end
      if (pkt_done) begin
        cursor_x_r  <= cursor_x_nxt;
        cursor_y_r  <= cursor_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && pos_r == mpct_pkg::POS_X) begin
      xmove_r <= in_packet_byte;
    end
    if (in_xfer && pos_r != mpct_pkg::POS_X && pos_r != mpct_pkg::POS_Y) begin
      status_r <= in_packet_byte;
    end
    if (pkt_done) begin
      out_old_x_r <= FB'(cursor_x_r);
      out_old_y_r <= FB'(cursor_y_r);
      out_new_x_r <= FB'(cursor_x_nxt);
      out_new_y_r <= FB'(cursor_y_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_old_x = out_old_x_r;
  assign out_old_y = out_old_y_r;
  assign out_new_x = out_new_x_r;
  assign out_new_y = out_new_y_r;

  `ASSERT_NEVER(a_pos_range, pos_r == 2'd3)
  `ASSERT_CLK(a_done_loads, pkt_done |=> out_valid_r && pos_r == mpct_pkg::POS_STATUS)
  `ASSERT_CLK(a_new_is_cursor, pkt_done |=> out_new_x_r == FB'(cursor_x_r) && out_new_y_r == FB'(cursor_y_r))
  `ASSERT_CLK(a_no_overwrite, out_valid_r && out_stall |-> !pkt_done)

endmodule

`default_nettype wire
